[rtl/core/abaa_pkg.sv]
// ----------------------------------------------------------------------------
// abaa_pkg
// Shared types and constants for the aligned bump arena allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package abaa_pkg;

   localparam int ARENA_BYTES_DEFAULT = 65535;
   localparam int OFFSET_W            = 16;
   localparam int ADDR_W              = 33;
   localparam int DIV_STEPS           = ADDR_W;
   localparam int CNT_W               = $clog2(DIV_STEPS + 1);

   localparam logic [OFFSET_W-1:0] TOP_RESET = 16'h0001;

   typedef enum logic [1:0] {
      FUNC_PUSH  = 2'd0,
      FUNC_POP   = 2'd1,
      FUNC_CLEAR = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_ZERO     = 2'd1,
      STATUS_OVERSIZE = 2'd2,
      STATUS_NOFIT    = 2'd3
   } status_type;

   typedef struct packed {
      logic load_in;
      logic div_step;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_done;
   } dp_status_type;

endpackage

`default_nettype wire

[rtl/core/abaa_ctrl.sv]
// ----------------------------------------------------------------------------
// abaa_ctrl
// Sequencer: accept, remainder loop, commit into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module abaa_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire abaa_pkg::dp_status_type dp_status,
   output abaa_pkg::ctrl_cmd_type     cmd
);
   import abaa_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.load_in  = (state_ff == S_IDLE) && req_valid;
      cmd.div_step = (state_ff == S_DIV) && dp_status.need_div && !dp_status.div_done;
      cmd.commit   = (state_ff == S_FINISH) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (!dp_status.need_div || dp_status.div_done) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("commit while output register holds an untaken item");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item accepted before the first one finished");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("committed item not presented");

   a_step_only_div: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (dp_status.need_div && (state_ff == S_DIV)))
      else $error("remainder step outside the divide phase");

endmodule

`default_nettype wire

[rtl/core/abaa_datapath.sv]
// ----------------------------------------------------------------------------
// abaa_datapath
// Arena state, base register, radix-2 remainder unit and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module abaa_datapath #(
   parameter int ARENA_BYTES = abaa_pkg::ARENA_BYTES_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_write,
   input  wire logic [31:0]             csr_arena_base_address,
   input  wire logic [1:0]              req_func,
   input  wire logic [31:0]             req_request_bytes,
   input  wire logic [15:0]             req_pop_offset,
   input  wire abaa_pkg::ctrl_cmd_type  cmd,
   output abaa_pkg::dp_status_type      dp_status,
   output logic [1:0]                   rsp_status,
   output logic [15:0]                  rsp_allocated_offset,
   output logic [15:0]                  rsp_top_offset,
   output logic [15:0]                  rsp_previous_top,
   output logic                         rsp_full_flag
);
   import abaa_pkg::*;

   localparam logic [31:0]         ARENA_LIMIT32 = 32'(ARENA_BYTES);
   localparam logic [OFFSET_W+1:0] ARENA_LIMIT18 = (OFFSET_W + 2)'(ARENA_BYTES);

   logic [31:0]          base_ff;
   logic [1:0]           func_ff;
   logic [31:0]          bytes_ff;
   logic [OFFSET_W-1:0]  popoff_ff;

   logic [OFFSET_W-1:0]  top_ff, top_in;
   logic [OFFSET_W-1:0]  prior_ff, prior_in;
   logic [OFFSET_W-1:0]  alloc_ff, alloc_in;
   logic                 full_ff, full_in;
   status_type           status_in;

   logic [ADDR_W-1:0]    raw_ff;
   logic [OFFSET_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]     cnt_ff;

   logic [1:0]           rsp_status_ff;
   logic [OFFSET_W-1:0]  rsp_alloc_ff, rsp_top_ff, rsp_prior_ff;
   logic                 rsp_full_ff;

   logic [OFFSET_W-1:0]  eff_top;
   logic [OFFSET_W-1:0]  divisor;
   logic                 is_zero, is_over, is_pow2;
   logic [OFFSET_W:0]    trial;
   logic [OFFSET_W-1:0]  rem_sel, adjust;
   logic [OFFSET_W+1:0]  offset, block_end;
   logic                 fits;

   assign eff_top = (top_ff == '0) ? TOP_RESET : top_ff;
   assign divisor = bytes_ff[OFFSET_W-1:0];
   assign is_zero = (bytes_ff == '0);
   assign is_over = (bytes_ff > ARENA_LIMIT32);
   assign is_pow2 = ((divisor & (divisor - 1'b1)) == '0);

   assign dp_status.need_div = (func_ff == FUNC_PUSH) && !is_zero && !is_over && !is_pow2;
   assign dp_status.div_done = (cnt_ff == '0);

   // one quotient bit per step, address MSB first
   always_comb begin
      trial = {rem_ff, raw_ff[ADDR_W-1]};
      if (trial >= {1'b0, divisor}) begin
         rem_in = OFFSET_W'(trial - {1'b0, divisor});
      end else begin
         rem_in = trial[OFFSET_W-1:0];
      end
   end

   assign rem_sel   = is_pow2 ? (raw_ff[OFFSET_W-1:0] & (divisor - 1'b1)) : rem_ff;
   assign adjust    = (rem_sel == '0) ? '0 : (divisor - rem_sel);
   assign offset    = {2'b00, eff_top} + {2'b00, adjust};
   assign block_end = offset + {2'b00, divisor};
   assign fits      = (block_end <= ARENA_LIMIT18);

   always_comb begin
      top_in    = top_ff;
      prior_in  = prior_ff;
      alloc_in  = alloc_ff;
      full_in   = full_ff;
      status_in = STATUS_DONE;
      case (func_ff)
         FUNC_PUSH: begin
            if (is_zero) begin
               status_in = STATUS_ZERO;
            end else if (is_over) begin
               status_in = STATUS_OVERSIZE;
            end else if (fits) begin
               alloc_in = offset[OFFSET_W-1:0];
               top_in   = block_end[OFFSET_W-1:0];
               prior_in = offset[OFFSET_W-1:0];
               full_in  = 1'b0;
            end else begin
               full_in   = 1'b1;
               status_in = STATUS_NOFIT;
            end
         end
         FUNC_POP: begin
            if (top_ff != TOP_RESET) begin
               if (top_ff > popoff_ff) begin
                  top_in   = prior_ff;
                  prior_in = popoff_ff;
               end
               full_in = 1'b0;
            end
         end
         FUNC_CLEAR: begin
            top_in   = TOP_RESET;
            prior_in = '0;
            alloc_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         top_ff   <= TOP_RESET;
         prior_ff <= '0;
         alloc_ff <= '0;
         full_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         if (csr_write) begin
            base_ff <= csr_arena_base_address;
         end
         if (cmd.load_in) begin
            cnt_ff <= CNT_W'(DIV_STEPS);
         end else if (cmd.div_step) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
         if (cmd.commit) begin
            top_ff   <= top_in;
            prior_ff <= prior_in;
            alloc_ff <= alloc_in;
            full_ff  <= full_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         func_ff   <= req_func;
         bytes_ff  <= req_request_bytes;
         popoff_ff <= req_pop_offset;
         raw_ff    <= {1'b0, base_ff} + {{(ADDR_W-OFFSET_W){1'b0}}, eff_top};
         rem_ff    <= '0;
      end else if (cmd.div_step) begin
         raw_ff <= {raw_ff[ADDR_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
      if (cmd.commit) begin
         rsp_status_ff <= status_in;
         rsp_alloc_ff  <= alloc_in;
         rsp_top_ff    <= top_in;
         rsp_prior_ff  <= prior_in;
         rsp_full_ff   <= full_in;
      end
   end

   assign rsp_status           = rsp_status_ff;
   assign rsp_allocated_offset = rsp_alloc_ff;
   assign rsp_top_offset       = rsp_top_ff;
   assign rsp_previous_top     = rsp_prior_ff;
   assign rsp_full_flag        = rsp_full_ff;

   a_top_in_arena: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && (func_ff == FUNC_PUSH) && (status_in == STATUS_DONE) && !is_zero
      |-> (block_end <= ARENA_LIMIT18))
      else $error("allocation past the end of the arena");

   a_nofit_sets_full: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && (status_in == STATUS_NOFIT) |=> full_ff)
      else $error("full flag not set on a failed push");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      dp_status.need_div && dp_status.div_done |-> (rem_ff < divisor))
      else $error("remainder not reduced below the size");

endmodule

`default_nettype wire

[rtl/core/aligned_bump_arena_allocator_top.sv]
// ----------------------------------------------------------------------------
// aligned_bump_arena_allocator_top
// Bump-pointer arena allocator with push, pop and clear requests.
// ----------------------------------------------------------------------------
// One item is worked on at a time. A push whose size is not a power of two
// goes through the divide phase between accept and result: the aligned address
// needs the remainder of the 33-bit absolute address by the size, found by a
// radix-2 restoring loop that retires one address bit per cycle. Every other
// item does no remainder steps. The result sits in an output register, so the
// next item is accepted while it waits to be taken. The base address register
// is written through the csr_ port, which is always ready; write it only while idle.
`default_nettype none

module aligned_bump_arena_allocator_top #(
   parameter int ARENA_BYTES = abaa_pkg::ARENA_BYTES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_arena_base_address,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_func,
   input  wire logic [31:0] req_request_bytes,
   input  wire logic [15:0] req_pop_offset,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_allocated_offset,
   output logic [15:0]      rsp_top_offset,
   output logic [15:0]      rsp_previous_top,
   output logic             rsp_full_flag
);
   import abaa_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   assign csr_ready = 1'b1;

   abaa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   abaa_datapath #(
      .ARENA_BYTES (ARENA_BYTES)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .csr_write              (csr_valid && csr_ready),
      .csr_arena_base_address (csr_arena_base_address),
      .req_func               (req_func),
      .req_request_bytes      (req_request_bytes),
      .req_pop_offset         (req_pop_offset),
      .cmd                    (cmd),
      .dp_status              (dp_status),
      .rsp_status             (rsp_status),
      .rsp_allocated_offset   (rsp_allocated_offset),
      .rsp_top_offset         (rsp_top_offset),
      .rsp_previous_top       (rsp_previous_top),
      .rsp_full_flag          (rsp_full_flag)
   );

endmodule

`default_nettype wire
